// ===== src/rtcm3_fsc_pkg.sv =====
// Shared constants, types and CRC-24Q byte update for the RTCM3 frame checker.
package rtcm3_fsc_pkg;

    localparam int          MAX_PAYLOAD = 1023;

    localparam int          BYTE_W   = 8;
    localparam int          LEN_W    = 10;
    localparam int          CNT_W    = 11;
    localparam int          CRC_W    = 24;
    localparam int          HDR_W    = 16;
    localparam int          MSG_W    = 12;
    localparam int          SUB_W    = 4;
    localparam int          STAT_W   = 3;
    localparam int          DATA_W   = 32;
    localparam int          ADDR_W   = 3;

    localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'hD3;
    localparam logic [CRC_W-1:0]  CRC_POLY  = 24'h864CFB;

    localparam logic [MSG_W-1:0]  EXP_MSG_RESET  = 12'd4095;
    localparam logic [HDR_W-1:0]  SUB_MASK_RESET = 16'd160;

    // register index is paddr[2]
    localparam logic REG_EXP_MSG  = 1'b0;
    localparam logic REG_SUB_MASK = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 3'd0,
        ST_CRC   = 3'd1,
        ST_MSG   = 3'd2,
        ST_SUB   = 3'd3,
        ST_SHORT = 3'd4
    } t_status;

    function automatic logic [CRC_W-1:0] crc24q_byte(input logic [CRC_W-1:0] crc,
                                                     input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {b, 16'h0000};
        for (int i = 0; i < BYTE_W; i++) begin
            if (c[CRC_W-1]) begin
                c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[CRC_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== src/rtcm3_frame_sync_crc_checker_core.sv =====
// RTCM3 frame synchronizer with CRC-24Q check and message number/subtype filter.
// One stream word is taken per cycle and, while the output is not stalled, the block
// sustains one word every cycle: a word is registered in the input register, then
// the framing state, the byte-wide CRC-24Q update and the status logic act on it,
// and the status word is registered in the output register. The block hunts for 0xD3,
// reads a 10-bit payload length, runs CRC-24Q over header and payload, and after
// the three CRC bytes reports accepted, CRC error, short payload, wrong message
// number or unaccepted subtype, then hunts again from the next word (no rescan).
// The input stalls only while a finished status word waits on a stalled output.
module rtcm3_frame_sync_crc_checker_core (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,

    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic [rtcm3_fsc_pkg::BYTE_W-1:0]       i_stream_byte,

    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic [rtcm3_fsc_pkg::STAT_W-1:0]       o_frame_status,
    output logic [rtcm3_fsc_pkg::MSG_W-1:0]        o_msg_number,
    output logic [rtcm3_fsc_pkg::SUB_W-1:0]        o_msg_subtype,
    output logic [rtcm3_fsc_pkg::LEN_W-1:0]        o_payload_length,

    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [rtcm3_fsc_pkg::ADDR_W-1:0]       paddr,
    input  logic [rtcm3_fsc_pkg::DATA_W-1:0]       pwdata,
    output logic [rtcm3_fsc_pkg::DATA_W-1:0]       prdata,
    output logic                                   pready
);

    typedef enum logic [3:0] {
        PH_HUNT   = 4'b0001,
        PH_HDR_HI = 4'b0010,
        PH_HDR_LO = 4'b0100,
        PH_BODY   = 4'b1000
    } t_phase;

    // config
    logic [rtcm3_fsc_pkg::MSG_W-1:0]  r_exp_msg;
    logic [rtcm3_fsc_pkg::HDR_W-1:0]  r_sub_mask;

    // input register
    logic                              r_in_vld;
    logic [rtcm3_fsc_pkg::BYTE_W-1:0]  r_in_byte;

    // framing state
    t_phase                            r_phase,    n_phase;
    logic [rtcm3_fsc_pkg::CNT_W-1:0]   r_cnt,      n_cnt;
    logic [rtcm3_fsc_pkg::LEN_W-1:0]   r_len,      n_len;
    logic [rtcm3_fsc_pkg::CRC_W-1:0]   r_crc,      n_crc;
    logic [rtcm3_fsc_pkg::CRC_W-1:0]   r_rcrc,     n_rcrc;
    logic [rtcm3_fsc_pkg::HDR_W-1:0]   r_hdr,      n_hdr;

    // output register
    logic                              r_out_vld;
    rtcm3_fsc_pkg::t_status            r_status,   n_status;
    logic [rtcm3_fsc_pkg::MSG_W-1:0]   r_num,      n_num;
    logic [rtcm3_fsc_pkg::SUB_W-1:0]   r_sub,      n_sub;
    logic [rtcm3_fsc_pkg::LEN_W-1:0]   r_out_len;

    logic                              proc_en;
    logic                              res_vld;
    logic                              cfg_wr;
    logic [rtcm3_fsc_pkg::CRC_W-1:0]   crc_upd;
    logic [rtcm3_fsc_pkg::CNT_W-1:0]   cnt_inc;
    logic [rtcm3_fsc_pkg::LEN_W-1:0]   hdr_len;
    logic                              short_pl;

    assign proc_en = !r_out_vld || !i_stall;
    assign o_stall = r_in_vld && !proc_en;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        prdata = '0;
        unique case (paddr[2])
            rtcm3_fsc_pkg::REG_EXP_MSG:  prdata[rtcm3_fsc_pkg::MSG_W-1:0] = r_exp_msg;
            rtcm3_fsc_pkg::REG_SUB_MASK: prdata[rtcm3_fsc_pkg::HDR_W-1:0] = r_sub_mask;
            default:                     prdata = '0;
        endcase
    end

    assign crc_upd  = rtcm3_fsc_pkg::crc24q_byte(r_crc, r_in_byte);
    assign cnt_inc  = r_cnt + 11'd1;
    assign hdr_len  = {r_hdr[9:8], r_in_byte};
    assign short_pl = (r_len < 10'd2);

    always_comb begin
        n_phase  = r_phase;
        n_cnt    = r_cnt;
        n_len    = r_len;
        n_crc    = r_crc;
        n_rcrc   = r_rcrc;
        n_hdr    = r_hdr;
        res_vld  = 1'b0;
        n_status = rtcm3_fsc_pkg::ST_OK;
        n_num    = short_pl ? '0 : r_hdr[15:4];
        n_sub    = short_pl ? '0 : r_hdr[3:0];
        if (r_in_vld && proc_en) begin
            unique case (r_phase)
                PH_HDR_HI: begin
                    n_crc   = crc_upd;
                    n_hdr   = {r_in_byte, 8'h00};
                    n_phase = PH_HDR_LO;
                end
                PH_HDR_LO: begin
                    n_crc   = crc_upd;
                    n_hdr   = {r_hdr[15:8], r_in_byte};
                    n_len   = hdr_len;
                    n_cnt   = '0;
                    n_rcrc  = '0;
                    n_phase = (32'(hdr_len) > 32'(rtcm3_fsc_pkg::MAX_PAYLOAD)) ?
                              PH_HUNT : PH_BODY;
                end
                PH_BODY: begin
                    if (r_cnt < {1'b0, r_len}) begin
                        n_crc = crc_upd;
                        if (r_cnt < 11'd2) begin
                            n_hdr = {r_hdr[7:0], r_in_byte};
                        end
                    end else begin
                        n_rcrc = {r_rcrc[15:0], r_in_byte};
                    end
                    n_cnt = cnt_inc;
                    if (cnt_inc == ({1'b0, r_len} + 11'd3)) begin
                        n_phase = PH_HUNT;
                        res_vld = 1'b1;
                        priority if (r_crc != n_rcrc) begin
                            n_status = rtcm3_fsc_pkg::ST_CRC;
                        end else if (short_pl) begin
                            n_status = rtcm3_fsc_pkg::ST_SHORT;
                        end else if (r_hdr[15:4] != r_exp_msg) begin
                            n_status = rtcm3_fsc_pkg::ST_MSG;
                        end else if (!r_sub_mask[r_hdr[3:0]]) begin
                            n_status = rtcm3_fsc_pkg::ST_SUB;
                        end else begin
                            n_status = rtcm3_fsc_pkg::ST_OK;
                        end
                    end
                end
                default: begin
                    n_phase = PH_HUNT;
                    if (r_in_byte == rtcm3_fsc_pkg::SYNC_BYTE) begin
                        n_crc   = rtcm3_fsc_pkg::crc24q_byte('0, r_in_byte);
                        n_hdr   = '0;
                        n_phase = PH_HDR_HI;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_msg  <= rtcm3_fsc_pkg::EXP_MSG_RESET;
            r_sub_mask <= rtcm3_fsc_pkg::SUB_MASK_RESET;
        end else if (cfg_wr && pready) begin
            unique case (paddr[2])
                rtcm3_fsc_pkg::REG_EXP_MSG:  r_exp_msg  <= pwdata[rtcm3_fsc_pkg::MSG_W-1:0];
                rtcm3_fsc_pkg::REG_SUB_MASK: r_sub_mask <= pwdata[rtcm3_fsc_pkg::HDR_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_stall) begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_byte <= i_stream_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_cnt   <= '0;
            r_len   <= '0;
            r_crc   <= '0;
            r_rcrc  <= '0;
            r_hdr   <= '0;
        end else begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_len   <= n_len;
            r_crc   <= n_crc;
            r_rcrc  <= n_rcrc;
            r_hdr   <= n_hdr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (proc_en) begin
            r_out_vld <= res_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_vld) begin
            r_status  <= n_status;
            r_num     <= n_num;
            r_sub     <= n_sub;
            r_out_len <= r_len;
        end
    end

    assign o_valid          = r_out_vld;
    assign o_frame_status   = r_status;
    assign o_msg_number     = r_num;
    assign o_msg_subtype    = r_sub;
    assign o_payload_length = r_out_len;

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the RTCM3 frame sync and CRC-24Q checker core.
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int BYTE_W = rtcm3_fsc_pkg::BYTE_W;
    localparam int LEN_W  = rtcm3_fsc_pkg::LEN_W;
    localparam int CNT_W  = rtcm3_fsc_pkg::CNT_W;
    localparam int CRC_W  = rtcm3_fsc_pkg::CRC_W;
    localparam int HDR_W  = rtcm3_fsc_pkg::HDR_W;
    localparam int MSG_W  = rtcm3_fsc_pkg::MSG_W;
    localparam int SUB_W  = rtcm3_fsc_pkg::SUB_W;
    localparam int STAT_W = rtcm3_fsc_pkg::STAT_W;
    localparam int DATA_W = rtcm3_fsc_pkg::DATA_W;
    localparam int ADDR_W = rtcm3_fsc_pkg::ADDR_W;

    localparam int unsigned CYCLE_LIMIT = 400000;

    typedef enum logic [1:0] {
        TRK_HUNT,
        TRK_HDR_HI,
        TRK_HDR_LO,
        TRK_BODY
    } t_trk_phase;

    typedef struct {
        rtcm3_fsc_pkg::t_status status;
        logic [MSG_W-1:0]       num;
        logic [SUB_W-1:0]       sub;
        logic [LEN_W-1:0]       len;
    } t_status_word;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [BYTE_W-1:0]  i_stream_byte = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [STAT_W-1:0]  o_frame_status;
    logic [MSG_W-1:0]   o_msg_number;
    logic [SUB_W-1:0]   o_msg_subtype;
    logic [LEN_W-1:0]   o_payload_length;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [ADDR_W-1:0]  paddr = '0;
    logic [DATA_W-1:0]  pwdata = '0;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    rtcm3_frame_sync_crc_checker_core dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_stream_byte    (i_stream_byte),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_frame_status   (o_frame_status),
        .o_msg_number     (o_msg_number),
        .o_msg_subtype    (o_msg_subtype),
        .o_payload_length (o_payload_length),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always #5ns i_clk = ~i_clk;

    // stimulus and expectations
    logic [BYTE_W-1:0]  stream_q[$];
    t_status_word       pending_status_q[$];
    int unsigned        err_count = 0;
    int unsigned        cycle_count = 0;
    bit                 no_gaps = 1'b0;
    int unsigned        gap_left = 0;
    int unsigned        hold_left = 0;

    // tracked copy of the framer
    logic [MSG_W-1:0]   want_msg = rtcm3_fsc_pkg::EXP_MSG_RESET;
    logic [15:0]        accept_mask = rtcm3_fsc_pkg::SUB_MASK_RESET;
    t_trk_phase         trk_phase = TRK_HUNT;
    logic [CNT_W-1:0]   trk_count = '0;
    logic [LEN_W-1:0]   trk_len = '0;
    logic [CRC_W-1:0]   trk_crc = '0;
    logic [CRC_W-1:0]   trk_crc_rx = '0;
    logic [HDR_W-1:0]   trk_hdr = '0;

    function automatic int unsigned draw_wait();
        return no_gaps ? 0 : $urandom_range(0, 7);
    endfunction

    function automatic logic [CRC_W-1:0] crc24q_step(input logic [CRC_W-1:0] acc,
                                                     input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] r;
        logic fb;
        r = acc;
        for (int k = BYTE_W - 1; k >= 0; k--) begin
            fb = r[CRC_W-1] ^ b[k];
            r = {r[CRC_W-2:0], 1'b0} ^ (fb ? rtcm3_fsc_pkg::CRC_POLY : '0);
        end
        return r;
    endfunction

    task automatic track_stream_byte(input logic [BYTE_W-1:0] b);
        t_status_word w;
        case (trk_phase)
            TRK_HDR_HI: begin
                trk_crc = crc24q_step(trk_crc, b);
                trk_hdr = {b, 8'h00};
                trk_phase = TRK_HDR_LO;
            end
            TRK_HDR_LO: begin
                trk_crc = crc24q_step(trk_crc, b);
                trk_hdr = {trk_hdr[15:8], b};
                trk_len = trk_hdr[LEN_W-1:0];
                trk_count = '0;
                trk_crc_rx = '0;
                trk_phase = (int'(trk_len) > rtcm3_fsc_pkg::MAX_PAYLOAD) ? TRK_HUNT : TRK_BODY;
            end
            TRK_BODY: begin
                if (trk_count < trk_len) begin
                    trk_crc = crc24q_step(trk_crc, b);
                    if (trk_count < 2) begin
                        trk_hdr = {trk_hdr[7:0], b};
                    end
                end else begin
                    trk_crc_rx = {trk_crc_rx[15:0], b};
                end
                trk_count = trk_count + 1'b1;
                if (trk_count == {1'b0, trk_len} + 11'd3) begin
                    trk_phase = TRK_HUNT;
                    if (trk_len >= 2) begin
                        w.num = trk_hdr[15:4];
                        w.sub = trk_hdr[3:0];
                    end else begin
                        w.num = '0;
                        w.sub = '0;
                    end
                    if (trk_crc != trk_crc_rx) begin
                        w.status = rtcm3_fsc_pkg::ST_CRC;
                    end else if (trk_len < 2) begin
                        w.status = rtcm3_fsc_pkg::ST_SHORT;
                    end else if (w.num != want_msg) begin
                        w.status = rtcm3_fsc_pkg::ST_MSG;
                    end else if (!accept_mask[w.sub]) begin
                        w.status = rtcm3_fsc_pkg::ST_SUB;
                    end else begin
                        w.status = rtcm3_fsc_pkg::ST_OK;
                    end
                    w.len = trk_len;
                    pending_status_q.push_back(w);
                end
            end
            default: begin
                trk_phase = TRK_HUNT;
                if (b == rtcm3_fsc_pkg::SYNC_BYTE) begin
                    trk_crc = crc24q_step('0, b);
                    trk_hdr = '0;
                    trk_phase = TRK_HDR_HI;
                end
            end
        endcase
    endtask

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            gap_left <= 0;
        end else begin
            if (i_valid && !o_stall) begin
                track_stream_byte(i_stream_byte);
            end
            if (!i_valid || !o_stall) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    i_valid <= 1'b0;
                end else if (stream_q.size() != 0) begin
                    i_valid <= 1'b1;
                    i_stream_byte <= stream_q.pop_front();
                    gap_left <= draw_wait();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // receiver and checker
    always @(posedge i_clk) begin : status_monitor
        int unsigned hold;
        t_status_word want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            hold_left <= 0;
        end else begin
            hold = hold_left;
            if (o_valid && !i_stall) begin
                if (pending_status_q.size() == 0) begin
                    $error("status word with none pending: status %0d length %0d",
                           o_frame_status, o_payload_length);
                    err_count++;
                end else begin
                    want = pending_status_q.pop_front();
                    if (o_frame_status !== want.status) begin
                        $error("frame_status: expected %0d, got %0d", want.status, o_frame_status);
                        err_count++;
                    end
                    if (o_msg_number !== want.num) begin
                        $error("msg_number: expected %0d, got %0d", want.num, o_msg_number);
                        err_count++;
                    end
                    if (o_msg_subtype !== want.sub) begin
                        $error("msg_subtype: expected %0d, got %0d", want.sub, o_msg_subtype);
                        err_count++;
                    end
                    if (o_payload_length !== want.len) begin
                        $error("payload_length: expected %0d, got %0d",
                               want.len, o_payload_length);
                        err_count++;
                    end
                end
                hold = draw_wait();
            end else if (o_valid && hold != 0) begin
                hold--;
            end
            hold_left <= hold;
            i_stall <= (hold != 0);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    task automatic write_reg(input logic reg_sel, input logic [DATA_W-1:0] data);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_sel, 2'b00};
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (reg_sel == rtcm3_fsc_pkg::REG_SUB_MASK) begin
            accept_mask = data[15:0];
        end else begin
            want_msg = data[MSG_W-1:0];
        end
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (stream_q.size() != 0 || i_valid || pending_status_q.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic queue_noise(input int unsigned n);
        logic [BYTE_W-1:0] b;
        repeat (n) begin
            b = BYTE_W'($urandom);
            if (b == rtcm3_fsc_pkg::SYNC_BYTE) begin
                b = ~b;
            end
            stream_q.push_back(b);
        end
    endtask

    // whole frame with a good CRC, or one flipped bit past the length field
    task automatic queue_frame(input logic [LEN_W-1:0] len, input logic [MSG_W-1:0] num,
                               input logic [SUB_W-1:0] sub, input bit corrupt);
        logic [BYTE_W-1:0] fb[$];
        logic [CRC_W-1:0] crc;
        int unsigned pos;
        fb.push_back(rtcm3_fsc_pkg::SYNC_BYTE);
        fb.push_back({6'($urandom), len[9:8]});
        fb.push_back(len[7:0]);
        for (int i = 0; i < int'(len); i++) begin
            if (i == 0) begin
                fb.push_back(num[11:4]);
            end else if (i == 1) begin
                fb.push_back({num[3:0], sub});
            end else begin
                fb.push_back(BYTE_W'($urandom));
            end
        end
        crc = '0;
        foreach (fb[i]) begin
            crc = crc24q_step(crc, fb[i]);
        end
        fb.push_back(crc[23:16]);
        fb.push_back(crc[15:8]);
        fb.push_back(crc[7:0]);
        if (corrupt) begin
            pos = $urandom_range(3, fb.size() - 1);
            fb[pos] = fb[pos] ^ (8'h01 << $urandom_range(0, 7));
        end
        foreach (fb[i]) begin
            stream_q.push_back(fb[i]);
        end
    endtask

    task automatic queue_random_frame(output int unsigned n_bytes);
        logic [LEN_W-1:0] len;
        logic [MSG_W-1:0] num;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
            len = LEN_W'($urandom_range(0, 1));
        end else if (pick < 85) begin
            len = LEN_W'($urandom_range(2, 8));
        end else begin
            len = LEN_W'($urandom_range(9, 60));
        end
        pick = $urandom_range(0, 9);
        if (pick < 5) begin
            num = want_msg;
        end else if (pick == 5) begin
            num = '0;
        end else if (pick == 6) begin
            num = '1;
        end else begin
            num = MSG_W'($urandom);
        end
        queue_frame(len, num, SUB_W'($urandom), $urandom_range(0, 99) < 15);
        n_bytes = int'(len) + 6;
    endtask

    initial begin
        int unsigned n;
        int unsigned fill;
        logic [MSG_W-1:0] exp_val;
        logic [15:0] mask_val;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: noise extremes, empty payload, accepted frame, short payload with bad CRC
        stream_q.push_back(8'h00);
        stream_q.push_back(8'hFF);
        queue_frame(10'd0, '0, '0, 1'b0);
        queue_frame(10'd2, 12'd4095, 4'd5, 1'b0);
        queue_frame(10'd1, 12'hABC, 4'd0, 1'b1);
        wait_drained();

        for (int p = 0; p < 7; p++) begin
            case (p)
                0: begin exp_val = '0;   mask_val = 16'hFFFF; end
                1: begin exp_val = '1;   mask_val = 16'h0000; end
                2: begin exp_val = MSG_W'($urandom); mask_val = 16'h0001; end
                3: begin exp_val = MSG_W'($urandom); mask_val = 16'h8000; end
                default: begin
                    exp_val = MSG_W'($urandom);
                    mask_val = 16'($urandom);
                end
            endcase
            write_reg(rtcm3_fsc_pkg::REG_EXP_MSG, {20'($urandom), exp_val});
            write_reg(rtcm3_fsc_pkg::REG_SUB_MASK, {16'($urandom), mask_val});
            no_gaps = (p == 1) || ($urandom_range(0, 3) == 0);
            fill = 0;
            while (fill < 40) begin
                if ($urandom_range(0, 9) == 0) begin
                    queue_noise($urandom_range(1, 6));
                end else begin
                    queue_random_frame(n);
                    fill += n;
                end
            end
            if (p == 4) begin
                queue_frame(10'd1023, want_msg, 4'd15, 1'b0);
            end
            wait_drained();
        end

        repeat (8) @(posedge i_clk);
        if (err_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
